@@ rtl/wrs_pkg.sv @@
// Package for the word reverser stream block.
// Holds sizes, character bounds, the classifier function and shared types.
// No dependencies.
`timescale 1ns / 1ps

package wrs_pkg;

  localparam int MAX_WORD    = 63;
  localparam int STORE_DEPTH = 63;
  localparam int CNT_W       = 6;
  localparam int CHAR_W      = 8;

  // Queue between the front and the back part.
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = 1;
  localparam int Q_CNT_W     = 2;

  // Result queue at the output.
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_PTR_W   = 2;
  localparam int OUT_CNT_W   = 3;

  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;

  typedef struct packed {
    logic [CHAR_W-1:0] char_b;
    logic              is_word;
  } wrs_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last;
    logic              split;
  } wrs_res_t;

  function automatic logic is_word_byte(input logic [CHAR_W-1:0] b);
    logic upper;
    logic lower;
    logic digit;
    upper = (b >= CH_UPPER_A) && (b <= CH_UPPER_Z);
    lower = (b >= CH_LOWER_A) && (b <= CH_LOWER_Z);
    digit = (b >= CH_DIGIT_0) && (b <= CH_DIGIT_9);
    return upper || lower || digit;
  endfunction

endpackage

@@ rtl/wrs_if.sv @@
// Channel interfaces for the word reverser stream block.
// One interface for the character input, one for the result output.
// No dependencies.
`timescale 1ns / 1ps

interface wrs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface wrs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;
  logic       split;

  modport source (output valid, output char_out, output last, output split, input ready);
  modport sink   (input valid, input char_out, input last, input split, output ready);
endinterface

@@ rtl/wrs_front.sv @@
// Front part: accepts input beats, classifies each byte and queues it.
// Depends on wrs_pkg and wrs_in_if.
`timescale 1ns / 1ps

module wrs_front import wrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  wrs_in_if.sink    in_ch,
  output logic      head_valid,
  output wrs_item_t head_item,
  input  logic      head_pop
);

  wrs_item_t            q_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 push;
  logic                 pop;

  assign in_ch.ready = (cnt_r != Q_CNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head_valid  = (cnt_r != '0);
  assign head_item   = q_r[rd_ptr_r];
  assign pop         = head_pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{char_b: in_ch.char_in, is_word: is_word_byte(in_ch.char_in)};
    end
  end

endmodule

@@ rtl/wrs_back.sv @@
// Back part: word stack in memory, drain sequencer and result queue.
// Depends on wrs_pkg and wrs_out_if.
`timescale 1ns / 1ps

module wrs_back import wrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  wrs_item_t head_item,
  output logic      head_pop,
  wrs_out_if.source out_ch
);

  typedef enum logic {ST_IDLE, ST_DRAIN} state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic                  rd_last_r, rd_last_nxt;
  logic                  rd_split_r, rd_split_nxt;
  logic [CHAR_W-1:0]     rd_data_r;
  logic [CHAR_W-1:0]     mem [STORE_DEPTH];

  wrs_res_t              fifo_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]  fwr_ptr_r, frd_ptr_r;
  logic [OUT_CNT_W-1:0]  fcnt_r;

  logic                  credit_ok;
  logic                  push_word;
  logic                  start_drain;
  logic                  sep_emit;
  logic                  rd_en;
  logic                  fifo_wr;
  logic                  fifo_rd;
  wrs_res_t              fifo_wdata;
  logic                  store_full;

  // A read may be issued only if the result queue has room for it and for the
  // read that may still be on its way out of the memory.
  assign credit_ok  = ({1'b0, fcnt_r} + {{OUT_CNT_W{1'b0}}, rd_vld_r})
                      < (OUT_CNT_W+1)'(OUT_DEPTH);
  assign store_full = (count_r >= CNT_W'(MAX_WORD));

  always_comb begin
    push_word    = 1'b0;
    start_drain  = 1'b0;
    sep_emit     = 1'b0;
    rd_en        = 1'b0;
    state_nxt    = state_r;
    count_nxt    = count_r;
    rd_vld_nxt   = 1'b0;
    rd_last_nxt  = rd_last_r;
    rd_split_nxt = rd_split_r;
    unique case (state_r)
      ST_IDLE: begin
        if (head_valid) begin
          if (head_item.is_word) begin
            push_word   = !store_full;
            start_drain = store_full;
          end else begin
            start_drain = (count_r != '0);
            sep_emit    = (count_r == '0) && !rd_vld_r
                          && (fcnt_r != OUT_CNT_W'(OUT_DEPTH));
          end
        end
        if (push_word) begin
          count_nxt = count_r + CNT_W'(1);
        end
        if (start_drain) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (credit_ok) begin
          rd_en        = 1'b1;
          rd_vld_nxt   = 1'b1;
          count_nxt    = count_r - CNT_W'(1);
          // Only a forced flush marks its final byte; after a separator's
          // word, the separator itself is the final result.
          rd_last_nxt  = head_item.is_word && (count_r == CNT_W'(1));
          rd_split_nxt = head_item.is_word;
          if (count_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign head_pop = push_word || sep_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_last_r  <= rd_last_nxt;
    rd_split_r <= rd_split_nxt;
  end

  // Word stack storage.
  always_ff @(posedge clk) begin
    if (push_word) begin
      mem[count_r] <= head_item.char_b;
    end
    if (rd_en) begin
      rd_data_r <= mem[count_r - CNT_W'(1)];
    end
  end

  // Result queue. Memory data and a separator never arrive in the same cycle.
  assign fifo_wr    = rd_vld_r || sep_emit;
  assign fifo_rd    = out_ch.valid && out_ch.ready;
  assign fifo_wdata = rd_vld_r
                      ? '{char_out: rd_data_r, last: rd_last_r, split: rd_split_r}
                      : '{char_out: head_item.char_b, last: 1'b1, split: 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwr_ptr_r <= '0;
      frd_ptr_r <= '0;
      fcnt_r    <= '0;
    end else begin
      if (fifo_wr) begin
        fwr_ptr_r <= fwr_ptr_r + OUT_PTR_W'(1);
      end
      if (fifo_rd) begin
        frd_ptr_r <= frd_ptr_r + OUT_PTR_W'(1);
      end
      fcnt_r <= fcnt_r + OUT_CNT_W'(fifo_wr) - OUT_CNT_W'(fifo_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_wr) begin
      fifo_r[fwr_ptr_r] <= fifo_wdata;
    end
  end

  assign out_ch.valid    = (fcnt_r != '0);
  assign out_ch.char_out = fifo_r[frd_ptr_r].char_out;
  assign out_ch.last     = fifo_r[frd_ptr_r].last;
  assign out_ch.split    = fifo_r[frd_ptr_r].split;

  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result queue overflow");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> count_r != '0)
    else $error("stack read with empty store");

  a_drain_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> head_valid)
    else $error("drain without a pending item");

  a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
    sep_emit |-> !rd_vld_r)
    else $error("two writers on the result queue");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_word |=> count_r != '0 && count_r <= CNT_W'(MAX_WORD))
    else $error("store count out of range after push");

endmodule

@@ rtl/word_reverser_stream_top.sv @@
// Channel   Dir  Beat payload                 Handshake
// in_ch     in   char_in[7:0]                 valid/ready
// out_ch    out  char_out[7:0], last, split   valid/ready
//
// A letter or digit is pushed onto the word stack. A separator first starts
// the drain, then the stored bytes are read newest first through the single
// stack memory read port as the result queue has room, and the separator is
// emitted once the read pipe has emptied.
// Reset is synchronous on rst_n and clears the queues and the stack count.
// Either side may stall: a two-entry queue and a four-entry result queue
// decouple them.
// Top level of the word reverser stream block; depends on wrs_pkg, wrs_if,
// wrs_front and wrs_back.
`timescale 1ns / 1ps

module word_reverser_stream_top import wrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  wrs_in_if.sink    in_ch,
  wrs_out_if.source out_ch
);

  logic      head_valid;
  wrs_item_t head_item;
  logic      head_pop;

  wrs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_pop   (head_pop)
  );

  wrs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_pop   (head_pop),
    .out_ch     (out_ch)
  );

endmodule

@@ verif/word_reverser_stream_checker.sv @@
// Scoreboard for the word reverser stream block: predicts the result beats
// from the accepted input beats and compares them in order.
// Depends on wrs_pkg and wrs_if.
`timescale 1ns / 1ps

module word_reverser_stream_checker import wrs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  wrs_in_if    in_ch,
  wrs_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   in_beats,
  output int   out_beats,
  output int   split_beats,
  output int   longest_run
);

  logic [CHAR_W-1:0] word_stack [STORE_DEPTH];
  logic [CNT_W-1:0]  stack_depth;
  wrs_res_t          expected_chars [$];
  int                run_len;

  function automatic logic is_alnum(input logic [CHAR_W-1:0] b);
    return (b >= CH_UPPER_A && b <= CH_UPPER_Z) ||
           (b >= CH_LOWER_A && b <= CH_LOWER_Z) ||
           (b >= CH_DIGIT_0 && b <= CH_DIGIT_9);
  endfunction

  // Pops the stored word, newest byte first. A forced flush marks its final
  // byte as last; an ordinary one leaves that to the separator.
  task automatic pop_word(input logic forced);
    wrs_res_t r;
    while (stack_depth != 0) begin
      stack_depth = stack_depth - 1'b1;
      r.char_out  = word_stack[stack_depth];
      r.last      = forced && (stack_depth == 0);
      r.split     = forced;
      expected_chars.push_back(r);
    end
  endtask

  task automatic reverse_word_step(input logic [CHAR_W-1:0] b);
    wrs_res_t r;
    if (is_alnum(b)) begin
      if (stack_depth >= MAX_WORD) begin
        pop_word(1'b1);
      end
      word_stack[stack_depth] = b;
      stack_depth = stack_depth + 1'b1;
      run_len++;
      if (run_len > longest_run) begin
        longest_run = run_len;
      end
    end else begin
      pop_word(1'b0);
      r.char_out = b;
      r.last     = 1'b1;
      r.split    = 1'b0;
      expected_chars.push_back(r);
      run_len = 0;
    end
  endtask

  task automatic report_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    wrs_res_t exp_r;
    if (!rst_n) begin
      stack_depth = '0;
      run_len     = 0;
      expected_chars.delete();
    end else begin
      // Prediction goes first so a beat can never be missed by ordering.
      if (in_ch.valid && in_ch.ready) begin
        in_beats++;
        reverse_word_step(in_ch.char_in);
      end
      if (out_ch.valid && out_ch.ready) begin
        out_beats++;
        if (out_ch.split) begin
          split_beats++;
        end
        if (expected_chars.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat, expected none, got char_out=%02h last=%0b split=%0b",
                   $time, out_ch.char_out, out_ch.last, out_ch.split);
        end else begin
          exp_r = expected_chars.pop_front();
          report_field("char_out", exp_r.char_out, out_ch.char_out);
          report_field("last", exp_r.last, out_ch.last);
          report_field("split", exp_r.split, out_ch.split);
        end
      end
    end
    pending = expected_chars.size();
  end

endmodule

@@ verif/word_reverser_stream_top_tb.sv @@
// Testbench top for the word reverser stream block: clock, reset, stimulus
// and back-pressure, with the scoreboard watching both channels.
// Depends on wrs_pkg, wrs_if, word_reverser_stream_top and the scoreboard.
`timescale 1ns / 1ps

module word_reverser_stream_top_tb import wrs_pkg::*; ();

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;
  bit   hold_req;
  bit   hold_done;

  int chk_fails;
  int chk_pending;
  int chk_in_beats;
  int chk_out_beats;
  int chk_split_beats;
  int chk_longest;

  wrs_in_if  in_ch ();
  wrs_out_if out_ch ();

  word_reverser_stream_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  word_reverser_stream_checker i_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (chk_fails),
    .pending     (chk_pending),
    .in_beats    (chk_in_beats),
    .out_beats   (chk_out_beats),
    .split_beats (chk_split_beats),
    .longest_run (chk_longest)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] rand_word_byte();
    case ($urandom_range(2))
      0:       return 8'($urandom_range(CH_DIGIT_9, CH_DIGIT_0));
      1:       return 8'($urandom_range(CH_UPPER_Z, CH_UPPER_A));
      default: return 8'($urandom_range(CH_LOWER_Z, CH_LOWER_A));
    endcase
  endfunction

  // Any byte outside the three alphanumeric ranges, high bytes included.
  function automatic logic [7:0] rand_sep_byte();
    case ($urandom_range(3))
      0:       return 8'($urandom_range(CH_DIGIT_0 - 1, 0));
      1:       return 8'($urandom_range(CH_UPPER_A - 1, CH_DIGIT_9 + 1));
      2:       return 8'($urandom_range(CH_LOWER_A - 1, CH_UPPER_Z + 1));
      default: return 8'($urandom_range(255, CH_LOWER_Z + 1));
    endcase
  endfunction

  // Entered and left at a falling edge. Valid stays high between back-to-back
  // beats, so it only gets lowered when the sender actually idles.
  task automatic send_char(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid   <= 1'b0;
      in_ch.char_in <= 8'($urandom);
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.char_in <= b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_word(input int len);
    repeat (len) send_char(rand_word_byte());
  endtask

  task automatic run_random(input int n_items);
    int sent;
    int k;
    int len;
    sent = 0;
    while (sent < n_items) begin
      k = $urandom_range(99);
      if (k < 70) begin
        len = ($urandom_range(99) < 4) ? $urandom_range(70, 60) : $urandom_range(8, 1);
        send_word(len);
        send_char(rand_sep_byte());
        sent += len + 1;
      end else if (k < 85) begin
        send_char(rand_sep_byte());
        sent++;
      end else begin
        send_char(8'($urandom));
        sent++;
      end
    end
  endtask

  // The sender stops offering beats while it waits.
  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
  endtask

  // Receiver side: random stalls, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.char_in = 8'h00;
    rst_n         = 1'b0;
    tx_idle_pct   = 6;
    rx_idle_pct   = 75;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: separators on an empty store, the class boundaries and their
    // neighbors, and short words closed by each kind of separator.
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h80);
    send_char(CH_UPPER_A);
    send_char(CH_UPPER_Z);
    send_char(CH_UPPER_A - 1'b1);
    send_char(CH_LOWER_A);
    send_char(CH_LOWER_Z);
    send_char(CH_UPPER_Z + 1'b1);
    send_char(CH_DIGIT_0);
    send_char(CH_DIGIT_9);
    send_char(CH_LOWER_A - 1'b1);
    send_char(CH_LOWER_Z + 1'b1);
    send_char(CH_DIGIT_0 - 1'b1);
    send_char(CH_DIGIT_9 + 1'b1);
    send_char(8'h7F);
    send_char(8'h20);

    // A word long enough to overflow the store twice.
    send_word(130);
    send_char(rand_sep_byte());
    run_random(50);

    tx_idle_pct = 75;
    rx_idle_pct = 6;
    // Exactly a full store, closed normally without a split.
    send_char(8'h20);
    send_word(MAX_WORD);
    send_char(rand_sep_byte());
    run_random(50);

    wait_results_done();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    repeat (12) begin
      send_word(2);
      send_char(rand_sep_byte());
    end
    in_ch.valid <= 1'b0;
    while (!hold_done) @(negedge clk);
    run_random(30);

    // Flush whatever word is still stored.
    send_char(8'h20);
    in_ch.valid <= 1'b0;
    wait_results_done();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d input beats and %0d result beats, %0d of them in split flushes.",
             chk_in_beats, chk_out_beats, chk_split_beats);
    $display("Longest letter/digit run was %0d bytes; one %0d-cycle receiver hold-off.",
             chk_longest, HOLD_CYCLES);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("word_reverser_stream_top_tb OK");
    end else begin
      $display("word_reverser_stream_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d result beats still expected.", chk_pending);
    $display("word_reverser_stream_top_tb NOT OK");
    $finish;
  end

endmodule
